@@ rtl/core/bsec_pkg.sv @@
`timescale 1ns / 1ps
// bsec_pkg: types and constants shared by the battery sense ema classifier
// no dependencies
package bsec_pkg;

   localparam int MV_W          = 16;
   localparam int SCALE_W       = 22;
   localparam int ALPHA_W       = 9;
   localparam int Q8_W          = 24;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 22;
   localparam int DIV_STEP_BITS = 8;
   localparam int QUEUE_DEPTH   = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ADC_MV_SCALE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_MV_SCALE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_FLOOR_MV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALID_MV     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID_MV     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MV           = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_MV      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA     = 3'd7;

   localparam logic [SCALE_W-1:0] RST_ADC_MV_SCALE     = 22'd52812;
   localparam logic [SCALE_W-1:0] RST_BATTERY_MV_SCALE = 22'd105625;
   localparam logic [MV_W-1:0]    RST_DETECT_FLOOR_MV  = 16'd1000;
   localparam logic [MV_W-1:0]    RST_MAX_VALID_MV     = 16'd5000;
   localparam logic [MV_W-1:0]    RST_MIN_VALID_MV     = 16'd3000;
   localparam logic [MV_W-1:0]    RST_LOW_MV           = 16'd3500;
   localparam logic [MV_W-1:0]    RST_CRITICAL_MV      = 16'd3300;
   localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA     = 9'd26;

   localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;
   localparam logic [MV_W-1:0]    MV_REJECT  = 16'hFFFF;
   localparam logic [MV_W-1:0]    MV_SAT     = 16'hFFFE;
   localparam logic [MV_W-1:0]    MV_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      SENSE_NOT_DETECTED = 2'd0,
      SENSE_BELOW_RANGE  = 2'd1,
      SENSE_VALID        = 2'd2,
      SENSE_INVALID      = 2'd3
   } sense_status_type;

   typedef enum logic [1:0] {
      MODE_BATTERY   = 2'd0,
      MODE_EXT_5V    = 2'd1,
      MODE_EXT_24V   = 2'd2,
      MODE_AMBIGUOUS = 2'd3
   } power_mode_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV_START,
      BK_DIV,
      BK_EMA_MUL,
      BK_EMA_ADD,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [SCALE_W-1:0] adc_mv_scale;
      logic [SCALE_W-1:0] battery_mv_scale;
      logic [MV_W-1:0]    detect_floor_mv;
      logic [MV_W-1:0]    max_valid_mv;
      logic [MV_W-1:0]    min_valid_mv;
      logic [MV_W-1:0]    low_mv;
      logic [MV_W-1:0]    critical_mv;
      logic [ALPHA_W-1:0] filter_alpha;
   } cfg_type;

endpackage

@@ rtl/core/battery_sense_ema_classifier_top.sv @@
`timescale 1ns / 1ps
// battery_sense_ema_classifier_top: csr bank, accumulator, queue and back end
// depends on bsec_pkg, bsec_front, bsec_queue, bsec_back
//
// usage:
//  req_* carries one converter sample and the 24 V power-good bit per word.
//  every SAMPLE_COUNT accepted words close a window; each window gives one
//  rsp_* word, other samples give none.
//  csr_* writes one register per word (index 0..7), always ready; write only
//  while the block is idle.
// timing:
//  samples are taken one per cycle while req_ready is high. per window the
//  back end steps through multiply, divider start, the divide-by-SAMPLE_COUNT
//  unit (STEPS = ceil((ADC_BITS + clog2(SAMPLE_COUNT) + 15) / 8) steps of 8
//  quotient bits), ema multiply, ema add and emit.
//  a two-entry queue holds closed windows; with windows shorter than the
//  back end time, req_ready drops on a closing sample until room frees up.
// stall: a held rsp word blocks the back end; sampling continues until a closing sample finds the queue full.
// reset: registers return to defaults, the filter becomes unprimed and the
//  partial window is dropped.
module battery_sense_ema_classifier_top
   import bsec_pkg::*;
#(
   parameter int SAMPLE_COUNT = 16,
   parameter int ADC_BITS     = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADC_BITS-1:0]   req_adc_sample,
   input  logic                  req_power_good_24v,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADC_BITS-1:0]   rsp_raw_adc,
   output logic [MV_W-1:0]       rsp_adc_mv,
   output logic [MV_W-1:0]       rsp_battery_mv,
   output logic                  rsp_battery_valid,
   output logic                  rsp_battery_low,
   output logic                  rsp_battery_critical,
   output logic                  rsp_external_24v,
   output logic                  rsp_external_powered,
   output logic [1:0]            rsp_power_mode,
   output logic                  rsp_battery_detected,
   output logic                  rsp_source_ambiguous,
   output logic [1:0]            rsp_sense_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = ADC_BITS + $clog2(SAMPLE_COUNT);

   cfg_type        cfg_ff, cfg_in;
   logic           q_full, push_valid, pop_valid, pop_ready;
   logic [SUM_W:0] push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ADC_MV_SCALE:     cfg_in.adc_mv_scale     = csr_wdata[SCALE_W-1:0];
            CSR_BATTERY_MV_SCALE: cfg_in.battery_mv_scale = csr_wdata[SCALE_W-1:0];
            CSR_DETECT_FLOOR_MV:  cfg_in.detect_floor_mv  = csr_wdata[MV_W-1:0];
            CSR_MAX_VALID_MV:     cfg_in.max_valid_mv     = csr_wdata[MV_W-1:0];
            CSR_MIN_VALID_MV:     cfg_in.min_valid_mv     = csr_wdata[MV_W-1:0];
            CSR_LOW_MV:           cfg_in.low_mv           = csr_wdata[MV_W-1:0];
            CSR_CRITICAL_MV:      cfg_in.critical_mv      = csr_wdata[MV_W-1:0];
            CSR_FILTER_ALPHA:     cfg_in.filter_alpha     = csr_wdata[ALPHA_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adc_mv_scale     <= RST_ADC_MV_SCALE;
         cfg_ff.battery_mv_scale <= RST_BATTERY_MV_SCALE;
         cfg_ff.detect_floor_mv  <= RST_DETECT_FLOOR_MV;
         cfg_ff.max_valid_mv     <= RST_MAX_VALID_MV;
         cfg_ff.min_valid_mv     <= RST_MIN_VALID_MV;
         cfg_ff.low_mv           <= RST_LOW_MV;
         cfg_ff.critical_mv      <= RST_CRITICAL_MV;
         cfg_ff.filter_alpha     <= RST_FILTER_ALPHA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsec_front #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .ADC_BITS     (ADC_BITS),
      .SUM_W        (SUM_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_adc_sample     (req_adc_sample),
      .req_power_good_24v (req_power_good_24v),
      .q_full             (q_full),
      .push_valid         (push_valid),
      .push_data          (push_data)
   );

   bsec_queue #(.WIDTH(SUM_W + 1)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bsec_back #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .ADC_BITS     (ADC_BITS),
      .SUM_W        (SUM_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_data             (pop_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_raw_adc          (rsp_raw_adc),
      .rsp_adc_mv           (rsp_adc_mv),
      .rsp_battery_mv       (rsp_battery_mv),
      .rsp_battery_valid    (rsp_battery_valid),
      .rsp_battery_low      (rsp_battery_low),
      .rsp_battery_critical (rsp_battery_critical),
      .rsp_external_24v     (rsp_external_24v),
      .rsp_external_powered (rsp_external_powered),
      .rsp_power_mode       (rsp_power_mode),
      .rsp_battery_detected (rsp_battery_detected),
      .rsp_source_ambiguous (rsp_source_ambiguous),
      .rsp_sense_status     (rsp_sense_status)
   );

   // reject code appears exactly for a not detected or invalid reading
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_battery_mv == MV_REJECT) ==
                     ((rsp_sense_status == SENSE_NOT_DETECTED) ||
                      (rsp_sense_status == SENSE_INVALID))))
      else $error("battery_mv reject code does not match sense status");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_battery_critical) |->
         (rsp_battery_detected && rsp_power_mode == MODE_BATTERY))
      else $error("critical flag without a detected battery");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_battery_valid) |-> (rsp_sense_status == SENSE_VALID))
      else $error("valid flag disagrees with sense status");

   // a closing sample is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("window pushed into a full queue");

endmodule

@@ rtl/core/bsec_front.sv @@
`timescale 1ns / 1ps
// bsec_front: sample window accumulator, pushes one window sum per window
// depends on bsec_pkg
module bsec_front
   import bsec_pkg::*;
#(
   parameter int SAMPLE_COUNT = 16,
   parameter int ADC_BITS     = 12,
   parameter int SUM_W        = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ADC_BITS-1:0] req_adc_sample,
   input  logic                req_power_good_24v,
   input  logic                q_full,
   output logic                push_valid,
   output logic [SUM_W:0]      push_data
);

   localparam int IDX_W = $clog2(SAMPLE_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);

   logic [SUM_W-1:0] sum_ff, sum_in, sum_next;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last, accept;

   assign last       = (idx_ff == LAST_IDX);
   // only the closing word of a window needs room in the queue
   assign req_ready  = !last || !q_full;
   assign accept     = req_valid && req_ready;
   assign sum_next   = sum_ff + SUM_W'(req_adc_sample);
   assign push_valid = accept && last;
   assign push_data  = {sum_next, req_power_good_24v};

   always_comb begin
      sum_in = sum_ff;
      idx_in = idx_ff;
      if (accept) begin
         if (last) begin
            sum_in = '0;
            idx_in = '0;
         end else begin
            sum_in = sum_next;
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         idx_ff <= idx_in;
      end
   end

endmodule

@@ rtl/core/bsec_queue.sv @@
`timescale 1ns / 1ps
// bsec_queue: short register queue between the accumulator and the back end
// depends on bsec_pkg
module bsec_queue
   import bsec_pkg::*;
#(
   parameter int WIDTH = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/bsec_div.sv @@
`timescale 1ns / 1ps
// bsec_div: iterative divider by a fixed divisor, several quotient bits per cycle
// depends on bsec_pkg
module bsec_div
   import bsec_pkg::*;
#(
   parameter int WIDTH   = 31,
   parameter int DIVISOR = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             busy,
   output logic [WIDTH-1:0] quotient
);

   localparam int STEPS = (WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int PAD_W = STEPS * DIV_STEP_BITS;
   localparam int REM_W = $clog2(DIVISOR + 1) + 1;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [REM_W-1:0] DIV_V     = REM_W'(DIVISOR);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic [PAD_W-1:0] quo_ff, quo_in, quo_step;
   logic [REM_W-1:0] rem_ff, rem_in, rem_step;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   // restoring division, remainder stays below the divisor so it is narrow
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         rem_step = {rem_step[REM_W-2:0], quo_step[PAD_W-1]};
         quo_step = {quo_step[PAD_W-2:0], 1'b0};
         if (rem_step >= DIV_V) begin
            rem_step    = rem_step - DIV_V;
            quo_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = PAD_W'(dividend);
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff[WIDTH-1:0];

endmodule

@@ rtl/core/bsec_back.sv @@
`timescale 1ns / 1ps
// bsec_back: per-window sequencer: scaling, range check, ema filter, classify
// depends on bsec_pkg and bsec_div
module bsec_back
   import bsec_pkg::*;
#(
   parameter int SAMPLE_COUNT = 16,
   parameter int ADC_BITS     = 12,
   parameter int SUM_W        = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  logic [SUM_W:0]      pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ADC_BITS-1:0] rsp_raw_adc,
   output logic [MV_W-1:0]     rsp_adc_mv,
   output logic [MV_W-1:0]     rsp_battery_mv,
   output logic                rsp_battery_valid,
   output logic                rsp_battery_low,
   output logic                rsp_battery_critical,
   output logic                rsp_external_24v,
   output logic                rsp_external_powered,
   output logic [1:0]          rsp_power_mode,
   output logic                rsp_battery_detected,
   output logic                rsp_source_ambiguous,
   output logic [1:0]          rsp_sense_status
);

   localparam int X_W   = SUM_W + SCALE_W;
   localparam int DIV_W = X_W - 7;
   localparam int N_W   = $clog2(SAMPLE_COUNT + 1);
   localparam int LIM_W = MV_W + N_W;
   localparam int CMP_W = (X_W > LIM_W + 16) ? X_W : LIM_W + 16;
   localparam int EMA_W = ALPHA_W + Q8_W;
   localparam logic [LIM_W-1:0] N_LIM     = LIM_W'(SAMPLE_COUNT);
   localparam logic [DIV_W-1:0] RAW_BIAS  = DIV_W'(SAMPLE_COUNT / 2);
   localparam logic [X_W:0]     ADC_BIAS  = (X_W + 1)'(SAMPLE_COUNT * 32768);
   localparam logic [X_W:0]     BATT_BIAS = (X_W + 1)'(SAMPLE_COUNT * 128);

   back_state_type state_ff, state_in;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              pg_ff, pg_in;
   logic [X_W-1:0]    prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [LIM_W-1:0]  floor_lim_ff, floor_lim_in, max_lim_ff, max_lim_in;
   sense_status_type  status_ff, status_in;
   logic [EMA_W-1:0]  mul_new_ff, mul_new_in, mul_old_ff, mul_old_in;
   logic [Q8_W-1:0]   filt_ff, filt_in;
   logic              primed_ff, primed_in;

   logic              div_start, div_busy, emit;
   logic [DIV_W-1:0]  div_raw_in, div_adc_in, div_rd_in;
   logic [DIV_W-1:0]  quo_raw, quo_adc, quo_rd;
   logic [X_W:0]      adc_biased, batt_biased;
   logic [CMP_W-1:0]  x_cmp, floor_cmp, max_cmp;
   logic [Q8_W-1:0]   reading;
   logic [ALPHA_W-1:0] alpha_eff;
   logic [EMA_W:0]    ema_sum;
   logic [Q8_W:0]     bmv_sum;
   logic [MV_W:0]     bmv_wide;
   logic [MV_W-1:0]   bmv_sat;
   logic              in_range, valid_v, detected_v;
   sense_status_type  status_out;
   power_mode_type    mode_v;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADC_BITS-1:0] raw_adc_ff;
   logic [MV_W-1:0]     adc_mv_ff, battery_mv_ff;
   logic                batt_valid_ff, batt_low_ff, batt_crit_ff, ext_24v_ff;
   logic                ext_powered_ff, detected_ff, ambiguous_ff;
   power_mode_type      mode_ff;
   sense_status_type    sense_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:      if (pop_valid) state_in = BK_MUL;
         BK_MUL:       state_in = BK_DIV_START;
         BK_DIV_START: state_in = BK_DIV;
         BK_DIV:       if (!div_busy) state_in = BK_EMA_MUL;
         BK_EMA_MUL:   state_in = BK_EMA_ADD;
         BK_EMA_ADD:   state_in = BK_EMIT;
         BK_EMIT:      if (emit) state_in = BK_IDLE;
         default:      state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop_ready = 1'b0;
      div_start = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         BK_IDLE:      pop_ready = 1'b1;
         BK_DIV_START: div_start = 1'b1;
         BK_EMIT:      emit = !rsp_valid_ff || rsp_ready;
         default:      pop_ready = 1'b0;
      endcase
   end

   assign adc_biased  = {1'b0, prod_a_ff} + ADC_BIAS;
   assign batt_biased = {1'b0, prod_b_ff} + BATT_BIAS;
   assign div_raw_in  = DIV_W'(sum_ff) + RAW_BIAS;
   assign div_adc_in  = DIV_W'(adc_biased[X_W:16]);
   assign div_rd_in   = batt_biased[X_W:8];

   bsec_div #(.WIDTH(DIV_W), .DIVISOR(SAMPLE_COUNT)) u_div_raw (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_raw_in),
      .busy     (div_busy),
      .quotient (quo_raw)
   );

   bsec_div #(.WIDTH(DIV_W), .DIVISOR(SAMPLE_COUNT)) u_div_adc (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_adc_in),
      .busy     (),
      .quotient (quo_adc)
   );

   bsec_div #(.WIDTH(DIV_W), .DIVISOR(SAMPLE_COUNT)) u_div_rd (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_rd_in),
      .busy     (),
      .quotient (quo_rd)
   );

   assign x_cmp     = CMP_W'(prod_b_ff);
   assign floor_cmp = CMP_W'({floor_lim_ff, 16'h0000});
   assign max_cmp   = CMP_W'({max_lim_ff, 16'h0000});
   assign reading   = quo_rd[Q8_W-1:0];
   assign alpha_eff = (cfg.filter_alpha > ALPHA_FULL) ? ALPHA_FULL : cfg.filter_alpha;
   assign ema_sum   = (EMA_W + 1)'(mul_new_ff) + (EMA_W + 1)'(mul_old_ff)
                    + (EMA_W + 1)'(128);

   // datapath registers
   always_comb begin
      sum_in       = sum_ff;
      pg_in        = pg_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      floor_lim_in = floor_lim_ff;
      max_lim_in   = max_lim_ff;
      status_in    = status_ff;
      mul_new_in   = mul_new_ff;
      mul_old_in   = mul_old_ff;
      filt_in      = filt_ff;
      primed_in    = primed_ff;
      if (pop_ready && pop_valid) begin
         sum_in = pop_data[SUM_W:1];
         pg_in  = pop_data[0];
      end
      if (state_ff == BK_MUL) begin
         prod_a_in    = X_W'(sum_ff) * X_W'(cfg.adc_mv_scale);
         prod_b_in    = X_W'(sum_ff) * X_W'(cfg.battery_mv_scale);
         floor_lim_in = LIM_W'(cfg.detect_floor_mv) * N_LIM;
         max_lim_in   = LIM_W'(cfg.max_valid_mv) * N_LIM;
      end
      if (state_ff == BK_DIV_START) begin
         if (x_cmp <= floor_cmp) begin
            status_in = SENSE_NOT_DETECTED;
         end else if (x_cmp > max_cmp) begin
            status_in = SENSE_INVALID;
         end else begin
            status_in = SENSE_BELOW_RANGE;
         end
      end
      if (state_ff == BK_EMA_MUL) begin
         mul_new_in = EMA_W'(alpha_eff) * EMA_W'(reading);
         mul_old_in = EMA_W'(ALPHA_FULL - alpha_eff) * EMA_W'(filt_ff);
      end
      if (state_ff == BK_EMA_ADD) begin
         if (status_ff != SENSE_BELOW_RANGE) begin
            // a rejected reading clears the filter
            filt_in   = '0;
            primed_in = 1'b0;
         end else if (!primed_ff) begin
            filt_in   = reading;
            primed_in = 1'b1;
         end else begin
            filt_in = ema_sum[Q8_W+7:8];
         end
      end
   end

   // classification of the finished window
   assign in_range   = (status_ff == SENSE_BELOW_RANGE);
   assign bmv_sum    = {1'b0, filt_ff} + (Q8_W + 1)'(128);
   assign bmv_wide   = bmv_sum[Q8_W:8];
   assign bmv_sat    = (bmv_wide > {1'b0, MV_SAT}) ? MV_SAT : bmv_wide[MV_W-1:0];
   assign valid_v    = in_range && (filt_ff >= {cfg.min_valid_mv, 8'h00});
   assign detected_v = in_range;

   always_comb begin
      status_out = status_ff;
      if (valid_v) begin
         status_out = SENSE_VALID;
      end
      if (detected_v) begin
         mode_v = MODE_BATTERY;
      end else if (pg_ff) begin
         mode_v = MODE_EXT_24V;
      end else if (status_ff == SENSE_INVALID) begin
         mode_v = MODE_AMBIGUOUS;
      end else begin
         mode_v = MODE_EXT_5V;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         status_ff    <= SENSE_NOT_DETECTED;
         filt_ff      <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         filt_ff      <= filt_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      pg_ff        <= pg_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      floor_lim_ff <= floor_lim_in;
      max_lim_ff   <= max_lim_in;
      mul_new_ff   <= mul_new_in;
      mul_old_ff   <= mul_old_in;
      if (emit) begin
         raw_adc_ff     <= quo_raw[ADC_BITS-1:0];
         adc_mv_ff      <= (quo_adc > DIV_W'(MV_MAX)) ? MV_MAX : quo_adc[MV_W-1:0];
         battery_mv_ff  <= in_range ? bmv_sat : MV_REJECT;
         batt_valid_ff  <= valid_v;
         batt_low_ff    <= in_range && (bmv_sat <= cfg.low_mv);
         batt_crit_ff   <= in_range && (bmv_sat <= cfg.critical_mv);
         ext_24v_ff     <= pg_ff;
         ext_powered_ff <= (mode_v == MODE_EXT_5V) || (mode_v == MODE_EXT_24V);
         mode_ff        <= mode_v;
         detected_ff    <= detected_v;
         ambiguous_ff   <= (detected_v && pg_ff) || (status_ff == SENSE_INVALID);
         sense_ff       <= status_out;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_raw_adc          = raw_adc_ff;
   assign rsp_adc_mv           = adc_mv_ff;
   assign rsp_battery_mv       = battery_mv_ff;
   assign rsp_battery_valid    = batt_valid_ff;
   assign rsp_battery_low      = batt_low_ff;
   assign rsp_battery_critical = batt_crit_ff;
   assign rsp_external_24v     = ext_24v_ff;
   assign rsp_external_powered = ext_powered_ff;
   assign rsp_power_mode       = mode_ff;
   assign rsp_battery_detected = detected_ff;
   assign rsp_source_ambiguous = ambiguous_ff;
   assign rsp_sense_status     = sense_ff;

endmodule
